// ----- sv/positional_list_engine_top_defines.svh -----
// Assertion macros for the positional list engine RTL.
// No dependencies; included by ple_ctrl, which carries concurrent assertions.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ple_pkg.sv -----
// Package for the positional list engine: operation codes, default depth
// and the command/status structs between controller and datapath. No dependencies.
package ple_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch an incoming word
        logic decode;   // check position, issue first read, set shift pointer
        logic fetch;    // keep the entry read for get or delete
        logic shift;    // move one entry and advance the pointer
        logic commit;   // write back count, insert value and result
    } ple_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       pos_ok;      // request is legal against the current count
        logic       ins_shift;   // insert lands below the tail, entries must move up
        logic       del_shift;   // delete leaves entries above it that must move down
        logic       shift_last;  // the current shift read is the final one
    } ple_stat_t;

endpackage

// ----- sv/ple_datapath.sv -----
// Datapath of the positional list engine: entry memory, count, shift pointer
// and result registers. Depends on ple_pkg.
module ple_datapath #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ple_pkg::ple_cmd_t   cmd,
    output ple_pkg::ple_stat_t  stat,
    input  logic [1:0]          in_op,
    input  logic [7:0]          in_position,
    input  logic signed [31:0]  in_write_value,
    output logic                res_ok,
    output logic signed [31:0]  res_read_value,
    output logic [7:0]          res_count_now
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0]       mem [DEPTH];

    logic [1:0]        op_reg;
    logic [7:0]        pos_reg;
    logic [31:0]       wval_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IW-1:0]     ptr_reg;
    logic              ok_reg;
    logic              wpend_reg;
    logic [IW-1:0]     waddr_reg;
    logic [31:0]       rdata_reg;
    logic [31:0]       keep_reg;
    logic              res_ok_reg;
    logic [31:0]       res_val_reg;
    logic [7:0]        res_cnt_reg;

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     idx_x;
    logic [IW-1:0]     idx;
    logic              pos_ok;
    logic              is_insert;
    logic              is_read_op;
    logic              mem_wen;
    logic [IW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic              mem_ren;
    logic [IW-1:0]     mem_raddr;

    assign pos_x     = XW'(pos_reg);
    assign cnt_x     = XW'(count_reg);
    assign idx_x     = pos_x - XW'(1);
    assign idx       = idx_x[IW-1:0];
    assign is_insert = (op_reg == ple_pkg::OP_INSERT);
    assign is_read_op = (op_reg == ple_pkg::OP_GET) || (op_reg == ple_pkg::OP_DELETE);

    always_comb begin
        unique case (op_reg)
            ple_pkg::OP_CLEAR:  pos_ok = 1'b1;
            ple_pkg::OP_INSERT: pos_ok = (pos_reg != 8'd0) && (pos_x <= cnt_x + XW'(1))
                                         && (cnt_x < XW'(DEPTH));
            default:            pos_ok = (pos_reg != 8'd0) && (pos_x <= cnt_x);
        endcase
    end

    always_comb begin
        stat.op         = op_reg;
        stat.pos_ok     = pos_ok;
        stat.ins_shift  = (pos_x <= cnt_x);
        stat.del_shift  = (pos_x < cnt_x);
        stat.shift_last = is_insert ? (ptr_reg == idx)
                                    : (XW'(ptr_reg) == cnt_x - XW'(1));
    end

    // A pending shift write and the insert write never fall in the same cycle.
    assign mem_wen   = wpend_reg || (cmd.commit && is_insert && ok_reg);
    assign mem_waddr = wpend_reg ? waddr_reg : idx;
    assign mem_wdata = wpend_reg ? rdata_reg : wval_reg;
    assign mem_ren   = cmd.decode || cmd.shift;
    assign mem_raddr = cmd.shift ? ptr_reg : idx;

    always_ff @(posedge aclk) begin
        if (mem_wen) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_ren) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (op_reg == ple_pkg::OP_CLEAR) begin
            count_next = '0;
        end else if (ok_reg && is_insert) begin
            count_next = count_reg + CW'(1);
        end else if (ok_reg && (op_reg == ple_pkg::OP_DELETE)) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end else begin
            wpend_reg <= cmd.shift;
            if (cmd.commit) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            pos_reg  <= in_position;
            wval_reg <= in_write_value;
        end
        if (cmd.decode) begin
            ok_reg  <= pos_ok;
            ptr_reg <= is_insert ? IW'(cnt_x - XW'(1)) : IW'(idx_x + XW'(1));
        end
        if (cmd.shift) begin
            waddr_reg <= is_insert ? ptr_reg + IW'(1) : ptr_reg - IW'(1);
            ptr_reg   <= is_insert ? ptr_reg - IW'(1) : ptr_reg + IW'(1);
        end
        if (cmd.fetch) begin
            keep_reg <= rdata_reg;
        end
        if (cmd.commit) begin
            res_ok_reg  <= ok_reg;
            res_val_reg <= (ok_reg && is_read_op) ? keep_reg : 32'd0;
            res_cnt_reg <= 8'(count_next);
        end
    end

    assign res_ok         = res_ok_reg;
    assign res_read_value = res_val_reg;
    assign res_count_now  = res_cnt_reg;

endmodule

// ----- sv/ple_ctrl.sv -----
// Controller of the positional list engine: sequences decode, fetch, shift
// and commit, and owns both handshakes. Depends on ple_pkg and the defines header.
`include "positional_list_engine_top_defines.svh"

module ple_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ple_pkg::ple_cmd_t   cmd,
    input  ple_pkg::ple_stat_t  stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (!stat.pos_ok) begin
                    state_next = ST_RESP;
                end else begin
                    unique case (stat.op)
                        ple_pkg::OP_GET,
                        ple_pkg::OP_DELETE: state_next = ST_FETCH;
                        ple_pkg::OP_INSERT: state_next = stat.ins_shift ? ST_SHIFT : ST_RESP;
                        default:            state_next = ST_RESP;
                    endcase
                end
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
                if ((stat.op == ple_pkg::OP_DELETE) && stat.del_shift) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.shift_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `PLE_ASSERT_NXT(a_commit_shows_word, aclk, aresetn, cmd.commit, m_tvalid, "commit without output word")
    `PLE_ASSERT_NXT(a_resp_waits, aclk, aresetn, (state_reg == ST_RESP) && out_valid_reg && !m_tready, state_reg == ST_RESP, "result overwrote an untaken word")
    `PLE_ASSERT_NXT(a_last_shift_drains, aclk, aresetn, (state_reg == ST_SHIFT) && stat.shift_last, state_reg == ST_DRAIN, "shift did not end after last step")
    `PLE_ASSERT_IMP(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

// ----- sv/positional_list_engine_top.sv -----
// Sequence: an accepted word goes through decode and then the response for clear, rejects
// and tail inserts; get and tail delete add a fetch, a mid-list insert adds a shift of k
// entries and a drain, and a mid-list delete a fetch, a shift of k entries and a drain
// (one entry per cycle through the one read port and the one write port of the memory).
// Throughput: one word at a time; s_tready rises again the cycle after the result is loaded.
// Reset (aresetn low, synchronous) empties the list and drops m_tvalid; stored entries keep
// their bits, and no stale entry reaches a result before being written again.
//
// Top level of the positional list engine. Depends on ple_pkg, ple_ctrl, ple_datapath.
module positional_list_engine_top #(
    parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position, [39:8] write_value
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [39:32] count_now
    output logic        m_tuser    // [0] ok
);

    // The controller only sequences; every piece of list state lives in the datapath.
    ple_pkg::ple_cmd_t  cmd;
    ple_pkg::ple_stat_t stat;

    logic signed [31:0] res_read_value;
    logic [7:0]         res_count_now;
    logic               res_ok;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the entry memory; an insert or delete walks the moved entries
    // one per cycle, reading one ahead of the write so the shift never overtakes itself.
    ple_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_tuser),
        .in_position    (s_tdata[7:0]),
        .in_write_value (s_tdata[39:8]),
        .res_ok         (res_ok),
        .res_read_value (res_read_value),
        .res_count_now  (res_count_now)
    );

    // The result registers hold still while m_tvalid waits for m_tready.
    assign m_tdata = {res_count_now, res_read_value};
    assign m_tuser = res_ok;

endmodule

// ----- tb/positional_list_engine_top_tb.sv -----
// Self-checking testbench for positional_list_engine_top: directed and random list operations
// with a shadow list that predicts every result. Depends on ple_pkg and the engine RTL.
module positional_list_engine_top_tb;

    localparam int LIST_DEPTH  = ple_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;   // long receiver hold-off, in cycles
    localparam int SETTLE      = 200;   // longer than the slowest shift through a full list

    localparam logic [31:0] WORD_MAX  = 32'h7fffffff;
    localparam logic [31:0] WORD_MIN  = 32'h80000000;
    localparam logic [31:0] WORD_ONES = 32'hffffffff;

    // Random mixes: balanced, biased toward growing and biased toward shrinking the list.
    localparam int MIX_EVEN   = 0;
    localparam int MIX_GROW   = 1;
    localparam int MIX_SHRINK = 2;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [7:0]  count_now;
    } list_result_t;

    // Shadow of the list: every accepted word updates it and queues the result it must give.
    class list_scoreboard;
        logic [31:0]  cells [LIST_DEPTH];
        int unsigned  live_count;
        int unsigned  peak_count;
        list_result_t awaited[$];
        int unsigned  failures;
        int unsigned  checked;
        int unsigned  rejected;
        int unsigned  op_totals[4];

        function new();
            live_count = 0;
            peak_count = 0;
            failures   = 0;
            checked    = 0;
            rejected   = 0;
            foreach (op_totals[i]) op_totals[i] = 0;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] pos, logic [31:0] wval);
            list_result_t res;
            int j;
            res.ok         = 1'b0;
            res.read_value = '0;
            op_totals[op]++;
            if (op == ple_pkg::OP_CLEAR) begin
                live_count = 0;
                res.ok     = 1'b1;
            end else if (op == ple_pkg::OP_INSERT) begin
                if (pos != 0 && pos <= live_count + 1 && live_count < LIST_DEPTH) begin
                    for (j = live_count; j >= pos; j--) cells[j] = cells[j - 1];
                    cells[pos - 1] = wval;
                    live_count++;
                    res.ok = 1'b1;
                end
            end else if (pos != 0 && pos <= live_count) begin
                res.read_value = cells[pos - 1];
                res.ok         = 1'b1;
                if (op == ple_pkg::OP_DELETE) begin
                    for (j = pos; j < live_count; j++) cells[j - 1] = cells[j];
                    live_count--;
                end
            end
            if (!res.ok) rejected++;
            if (live_count > peak_count) peak_count = live_count;
            res.count_now = live_count[7:0];
            awaited.push_back(res);
        endfunction

        function void check_result(logic ok, logic [31:0] read_value, logic [7:0] count_now);
            list_result_t exp_res;
            checked++;
            if (awaited.size() == 0) begin
                failures++;
                $display("%0t: result with nothing awaited: ok=%b read_value=%h count_now=%0d",
                         $time, ok, read_value, count_now);
                return;
            end
            exp_res = awaited.pop_front();
            if (ok !== exp_res.ok) begin
                failures++;
                $display("%0t: ok mismatch: expected %b actual %b", $time, exp_res.ok, ok);
            end
            if (read_value !== exp_res.read_value) begin
                failures++;
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, exp_res.read_value, read_value);
            end
            if (count_now !== exp_res.count_now) begin
                failures++;
                $display("%0t: count_now mismatch: expected %0d actual %0d",
                         $time, exp_res.count_now, count_now);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [7:0] position, [39:8] write_value
    logic [1:0]  s_tuser  = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] read_value, [39:32] count_now
    logic        m_tuser;         // [0] ok

    list_scoreboard sb;
    int unsigned    cycle_count  = 0;
    bit             no_idle      = 1'b0;   // both sides run without gaps while set
    bit             hold_request = 1'b0;   // asks the receiver for one long hold-off

    positional_list_engine_top #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit of %0d", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Every result word taken by the receiver is compared against the oldest prediction.
    // The outputs are read at the edge, before any update scheduled by that edge lands.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[39:32]);
        end
    end

    // Receiver: alternates runs of ready and not-ready, mostly short gaps with a few long
    // ones. On request it holds m_tready low through one long hold-off so the engine backs
    // up and stops taking words on its input side.
    initial begin : result_sink
        int  run_left;
        int  hold_left;
        bit  run_ready;
        run_left  = 0;
        hold_left = 0;
        run_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    if (run_ready) begin
                        run_left = $urandom_range(1, 16);
                    end else if ($urandom_range(0, 9) == 0) begin
                        run_left = $urandom_range(20, 60);
                    end else begin
                        run_left = $urandom_range(1, 3);
                    end
                end
                m_tready <= run_ready;
                run_left--;
            end
        end
    end

    // Idle cycles the sender leaves after a word: half none, most of the rest short.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word, hold it until the engine takes it, then record it in the shadow list.
    // A zero gap leaves tvalid high so the next word follows at once.
    task automatic send_word(input logic [1:0] op, input logic [7:0] pos,
                             input logic [31:0] wval);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wval, pos};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, pos, wval);
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop the request and wait for every outstanding result to come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    // Build one random request against the current shadow length. Most positions are legal
    // so the list grows and shrinks; the rest sit on the boundary or anywhere in 0..255.
    function automatic void pick_request(input int mix, output logic [1:0] op,
                                         output logic [7:0] pos, output logic [31:0] wval);
        int          r;
        int          ins_cut;
        int          get_cut;
        int          del_cut;
        int unsigned n;
        n = sb.live_count;
        case (mix)
            MIX_GROW: begin
                ins_cut = 60; get_cut = 75; del_cut = 98;
            end
            MIX_SHRINK: begin
                ins_cut = 20; get_cut = 40; del_cut = 99;
            end
            default: begin
                ins_cut = 40; get_cut = 70; del_cut = 98;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_cut)      op = ple_pkg::OP_INSERT;
        else if (r < get_cut) op = ple_pkg::OP_GET;
        else if (r < del_cut) op = ple_pkg::OP_DELETE;
        else                  op = ple_pkg::OP_CLEAR;

        r = $urandom_range(0, 99);
        if (r < 85) begin
            if (op == ple_pkg::OP_INSERT) pos = 8'($urandom_range(1, n + 1));
            else                          pos = (n == 0) ? 8'd1 : 8'($urandom_range(1, n));
        end else if (r < 93) begin
            case ($urandom_range(0, 3))
                0:       pos = 8'd0;
                1:       pos = 8'(n);
                2:       pos = 8'(n + 1);
                default: pos = 8'(n + 2);
            endcase
        end else begin
            pos = 8'($urandom_range(0, 255));
        end

        r = $urandom_range(0, 99);
        if (r < 90) begin
            wval = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       wval = '0;
                1:       wval = WORD_ONES;
                2:       wval = WORD_MAX;
                default: wval = WORD_MIN;
            endcase
        end
    endfunction

    task automatic send_random(input int mix, input int words);
        logic [1:0]  op;
        logic [7:0]  pos;
        logic [31:0] wval;
        repeat (words) begin
            pick_request(mix, op, pos, wval);
            send_word(op, pos, wval);
        end
    endtask

    initial begin : stimulus
        logic [31:0] wval;
        int          phase;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: rejects on the empty list, inserts at head, tail and middle,
        // reads at both ends and past the end, deletes from middle, tail and head,
        // then a clear, the rejects that follow it and an insert into the emptied list.
        send_word(ple_pkg::OP_GET,    8'd1,   '0);
        send_word(ple_pkg::OP_DELETE, 8'd1,   '0);
        send_word(ple_pkg::OP_GET,    8'd0,   '0);
        send_word(ple_pkg::OP_INSERT, 8'd0,   32'h12345678);
        send_word(ple_pkg::OP_INSERT, 8'd2,   32'h12345678);
        send_word(ple_pkg::OP_INSERT, 8'd1,   WORD_MAX);
        send_word(ple_pkg::OP_INSERT, 8'd1,   WORD_MIN);
        send_word(ple_pkg::OP_INSERT, 8'd3,   WORD_ONES);
        send_word(ple_pkg::OP_INSERT, 8'd2,   '0);
        send_word(ple_pkg::OP_GET,    8'd0,   '0);
        send_word(ple_pkg::OP_GET,    8'd1,   '0);
        send_word(ple_pkg::OP_GET,    8'd4,   '0);
        send_word(ple_pkg::OP_GET,    8'd5,   '0);
        send_word(ple_pkg::OP_GET,    8'd255, WORD_ONES);
        send_word(ple_pkg::OP_INSERT, 8'd6,   32'h0badf00d);
        send_word(ple_pkg::OP_DELETE, 8'd0,   '0);
        send_word(ple_pkg::OP_DELETE, 8'd2,   '0);
        send_word(ple_pkg::OP_DELETE, 8'd3,   '0);
        send_word(ple_pkg::OP_DELETE, 8'd1,   '0);
        send_word(ple_pkg::OP_INSERT, 8'd2,   32'h5a5a5a5a);
        send_word(ple_pkg::OP_CLEAR,  8'd0,   '0);
        send_word(ple_pkg::OP_GET,    8'd1,   '0);
        send_word(ple_pkg::OP_DELETE, 8'd1,   '0);
        send_word(ple_pkg::OP_INSERT, 8'd1,   32'ha5a5a5a5);

        // Fill the list to capacity at random legal positions, then probe the full list:
        // inserts must be refused, the last entry is readable and removable.
        while (sb.live_count < LIST_DEPTH) begin
            wval = $urandom;
            send_word(ple_pkg::OP_INSERT, 8'($urandom_range(1, sb.live_count + 1)), wval);
        end
        send_word(ple_pkg::OP_INSERT, 8'(LIST_DEPTH + 1), 32'h11111111);
        send_word(ple_pkg::OP_INSERT, 8'(LIST_DEPTH),     32'h22222222);
        send_word(ple_pkg::OP_INSERT, 8'd1,               32'h33333333);
        send_word(ple_pkg::OP_GET,    8'(LIST_DEPTH),     '0);
        send_word(ple_pkg::OP_GET,    8'(LIST_DEPTH + 1), '0);
        send_word(ple_pkg::OP_DELETE, 8'(LIST_DEPTH),     '0);

        // Long receiver hold-off while the sender keeps offering words.
        hold_request = 1'b1;
        send_random(MIX_EVEN, 30);

        // The sender stops until every result is back.
        drain_results();

        // Random bulk: shrink, grow and balanced passes so the length sweeps its whole range,
        // with one pass where neither side idles.
        for (phase = 0; phase < 6; phase++) begin
            no_idle = (phase == 3);
            case (phase % 3)
                0:       send_random(MIX_SHRINK, 50);
                1:       send_random(MIX_GROW, 50);
                default: send_random(MIX_EVEN, 50);
            endcase
        end
        no_idle = 1'b0;

        drain_results();
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d words (%0d get, %0d insert, %0d delete, %0d clear), %0d rejected;",
                 sb.checked, sb.op_totals[ple_pkg::OP_GET], sb.op_totals[ple_pkg::OP_INSERT],
                 sb.op_totals[ple_pkg::OP_DELETE], sb.op_totals[ple_pkg::OP_CLEAR],
                 sb.rejected);
        $display("list length peaked at %0d of %0d entries.", sb.peak_count, LIST_DEPTH);
        if (sb.failures == 0 && sb.awaited.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
